@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/wcs_pkg.sv @@
package wcs_pkg;

	localparam int PACKETS_PER_CHUNK = 512;
	localparam int CAP_INT = (PACKETS_PER_CHUNK > 1023) ? 1023 : PACKETS_PER_CHUNK;

	localparam logic [9:0]  CAP           = 10'(CAP_INT);
	localparam logic [10:0] CHUNK_END     = 11'(PACKETS_PER_CHUNK);
	localparam logic [10:0] ROUND_MAX     = 11'd2047;
	localparam logic [9:0]  MIN_THRESHOLD = 10'd2;
	localparam logic [1:0]  DUP_TRIGGER   = 2'd2;

	localparam logic [1:0] ACT_START   = 2'd0;
	localparam logic [1:0] ACT_ACK     = 2'd1;
	localparam logic [1:0] ACT_TIMEOUT = 2'd2;

	localparam logic [1:0] TIMER_LEAVE   = 2'd0;
	localparam logic [1:0] TIMER_STOP    = 2'd1;
	localparam logic [1:0] TIMER_RESTART = 2'd2;

	localparam logic [1:0] CFG_INITIAL_WINDOW    = 2'd0;
	localparam logic [1:0] CFG_INITIAL_THRESHOLD = 2'd1;

	localparam logic [9:0] RESET_INITIAL_WINDOW    = 10'd1;
	localparam logic [9:0] RESET_INITIAL_THRESHOLD = 10'd64;

	typedef struct packed {
		logic        active;
		logic [9:0]  window;
		logic [9:0]  threshold;
		logic [9:0]  last_acked;
		logic [1:0]  duplicate_count;
		logic [10:0] round_mark;
		logic [9:0]  next_to_send;
		logic [9:0]  send_limit;
	} state_t;

	typedef struct packed {
		logic [9:0] initial_window;
		logic [9:0] initial_threshold;
	} cfg_t;

	typedef struct packed {
		logic [9:0] send_first;
		logic [9:0] send_count;
		logic       transfer_done;
		logic [1:0] timer_command;
		logic [9:0] window_now;
	} result_t;

	localparam state_t STATE_RESET = '{
		active:          1'b0,
		window:          10'd1,
		threshold:       10'd64,
		last_acked:      10'd0,
		duplicate_count: 2'd0,
		round_mark:      11'd0,
		next_to_send:    10'd0,
		send_limit:      10'd0
	};

	function automatic logic [9:0] sat_cap(input logic [10:0] v);
		return (v > {1'b0, CAP}) ? CAP : v[9:0];
	endfunction

	function automatic logic [10:0] sat_round(input logic [11:0] v);
		return (v > {1'b0, ROUND_MAX}) ? ROUND_MAX : v[10:0];
	endfunction

endpackage

@@ rtl/window_congestion_sender.sv @@
// Congestion-window sender for one chunk transfer. Each transaction on the
// input channel is a start, a cumulative ACK or a timer expiry, and yields
// exactly one result: the run of packet indices to send now, a timer command
// and the window after the event. Sustained rate, set by the combinational
// window/pointer state update, is one event per cycle while the receiver takes
// each result. An event waits in the input register until the result register
// is free; its result is then held there until the receiver takes it. While a
// result waits, at most one further event is taken into the input register
// and the input then stalls until the result is taken. Configuration writes
// take effect for the next start event and are accepted in every cycle.
module window_congestion_sender import wcs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data,

	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [9:0] ack_number,

	output logic       out_valid,
	input  logic       out_ready,
	output logic [9:0] send_first,
	output logic [9:0] send_count,
	output logic       transfer_done,
	output logic [1:0] timer_command,
	output logic [9:0] window_now
);

	cfg_t       cfg_q;
	state_t     state_q;
	state_t     state_nxt;
	result_t    res_nxt;
	result_t    res_q;
	logic       valid_s1;
	logic [1:0] action_s1;
	logic [9:0] ack_s1;
	logic       out_valid_q;
	logic       advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.initial_window    <= RESET_INITIAL_WINDOW;
			cfg_q.initial_threshold <= RESET_INITIAL_THRESHOLD;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_INITIAL_WINDOW:    cfg_q.initial_window    <= cfg_data;
				CFG_INITIAL_THRESHOLD: cfg_q.initial_threshold <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture the event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			ack_s1    <= ack_number;
		end
	end

	wcs_step u_step (
		.cur        (state_q),
		.cfg        (cfg_q),
		.action     (action_s1),
		.ack_number (ack_s1),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				state_q <= state_nxt;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_nxt;
	end

	assign out_valid     = out_valid_q;
	assign send_first    = res_q.send_first;
	assign send_count    = res_q.send_count;
	assign transfer_done = res_q.transfer_done;
	assign timer_command = res_q.timer_command;
	assign window_now    = res_q.window_now;

endmodule

@@ rtl/wcs_step.sv @@
module wcs_step import wcs_pkg::*; (
	input  state_t     cur,
	input  cfg_t       cfg,
	input  logic [1:0] action,
	input  logic [9:0] ack_number,
	output state_t     nxt,
	output result_t    res
);

	logic [9:0]  start_win;
	logic [9:0]  slow_win;
	logic [9:0]  inc_win;
	logic [9:0]  half_win;
	logic [9:0]  collapse_thr;
	logic [9:0]  ack_gap;
	logic        send;

	always_comb begin
		ack_gap      = ack_number - cur.last_acked;
		start_win    = (cfg.initial_window == 10'd0) ? 10'd1 : cfg.initial_window;
		start_win    = (start_win > CAP) ? CAP : start_win;
		slow_win     = sat_cap({1'b0, cur.window} + {1'b0, ack_gap});
		inc_win      = sat_cap({1'b0, cur.window} + 11'd1);
		half_win     = cur.window >> 1;
		collapse_thr = (half_win >= MIN_THRESHOLD) ? half_win : MIN_THRESHOLD;

		nxt               = cur;
		send              = 1'b0;
		res.transfer_done = 1'b0;
		res.timer_command = TIMER_LEAVE;

		unique case (action)
			ACT_START: begin
				nxt.active          = 1'b1;
				nxt.window          = start_win;
				nxt.threshold       = cfg.initial_threshold;
				nxt.last_acked      = 10'd0;
				nxt.duplicate_count = 2'd0;
				nxt.round_mark      = 11'd0;
				nxt.next_to_send    = 10'd0;
				nxt.send_limit      = start_win;
				send                = 1'b1;
			end
			ACT_ACK: begin
				if (cur.active) begin
					priority if ({1'b0, ack_number} == CHUNK_END) begin
						res.timer_command = TIMER_STOP;
						res.transfer_done = 1'b1;
						nxt.active        = 1'b0;
					end else if (ack_number > cur.last_acked) begin
						nxt.last_acked      = ack_number;
						nxt.duplicate_count = 2'd0;
						if (cur.window < cur.threshold) begin
							nxt.window     = slow_win;
							nxt.round_mark = sat_round({2'b0, ack_number} + {2'b0, slow_win});
						end else if ({1'b0, ack_number} >= cur.round_mark) begin
							nxt.window     = inc_win;
							nxt.round_mark = sat_round({1'b0, cur.round_mark} + {2'b0, inc_win});
						end
						if (ack_number > cur.next_to_send)
							nxt.next_to_send = ack_number;
						nxt.send_limit = sat_cap({1'b0, ack_number} + {1'b0, nxt.window});
						send           = 1'b1;
					end else if (ack_number == cur.last_acked) begin
						if (cur.duplicate_count == DUP_TRIGGER) begin
							nxt.duplicate_count = 2'd0;
							nxt.next_to_send    = ack_number;
							nxt.threshold       = collapse_thr;
							nxt.window          = 10'd1;
							nxt.send_limit      = sat_cap({1'b0, ack_number} + 11'd1);
							send                = 1'b1;
						end else begin
							nxt.duplicate_count = cur.duplicate_count + 2'd1;
						end
					end
				end
			end
			ACT_TIMEOUT: begin
				if (cur.active) begin
					nxt.next_to_send    = cur.last_acked;
					nxt.duplicate_count = 2'd0;
					nxt.threshold       = collapse_thr;
					nxt.window          = 10'd1;
					nxt.send_limit      = sat_cap({1'b0, cur.last_acked} + 11'd1);
					send                = 1'b1;
				end
			end
			default: ;
		endcase

		res.send_first = nxt.next_to_send;
		res.send_count = 10'd0;
		if (send) begin
			res.timer_command = TIMER_RESTART;
			if (nxt.send_limit > nxt.next_to_send) begin
				res.send_count   = nxt.send_limit - nxt.next_to_send;
				nxt.next_to_send = nxt.send_limit;
			end
		end
		res.window_now = nxt.window;
	end

endmodule

@@ rtl/wcs_checker.sv @@
`include "assert_macros.svh"

module wcs_checker import wcs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [9:0] send_first,
	input logic [9:0] send_count,
	input logic       transfer_done,
	input logic [1:0] timer_command,
	input logic [9:0] window_now
);

	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(send_first) && $stable(send_count) && $stable(window_now),
		"stalled result changed")
	`ASSERT_SAME(a_done_stops, out_valid && transfer_done,
		timer_command == TIMER_STOP && send_count == 10'd0, "done without timer stop")
	`ASSERT_SAME(a_send_restarts, out_valid && send_count != 10'd0,
		timer_command == TIMER_RESTART, "send without timer restart")
	`ASSERT_SAME(a_window_range, out_valid,
		window_now != 10'd0 && window_now <= CAP && send_count <= CAP,
		"window or run out of range")

endmodule

bind window_congestion_sender wcs_checker u_wcs_checker (.*);
